// ===== rtl/peml_pkg.sv =====
// Shared constants, register codes and controller/datapath bundles for the
// Prewitt edge magnitude block. No dependencies.
package peml_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  // Reset values of the frame geometry registers
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Datapath widths: sum of three pixels, |difference|, quotient, squares
  localparam int SUM_W  = PIX_W + 2;
  localparam int DIFF_W = PIX_W + 2;
  localparam int Q_W    = 7;
  localparam int SQ_W   = 2 * Q_W + 1;
  localparam int ROOT_W = SQ_W;

  // Divide by 6 as multiply by 683 and shift right by 12 (exact for |x| < 2048)
  localparam int RECIP_W     = 10;
  localparam int RECIP_SHIFT = 12;
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(683);
  localparam int PROD_W = DIFF_W + RECIP_W;

  // First trial bit of the square root: highest even power of two below 2^SQ_W
  localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = ROOT_W'(1) << (ROOT_W - 1);

  typedef struct packed {
    logic load;      // capture pixel, start line-buffer read
    logic win;       // update line buffers, window and counters
    logic diff;      // register |Gx|*6 and |Gy|*6
    logic div;       // scale by 1/6
    logic sqr;       // square and sum, seed root
    logic root;      // one square-root step
    logic out_load;  // move result into output register
  } peml_cmd_t;

  typedef struct packed {
    logic emit;       // window centre is interior
    logic root_last;  // current root step is the final one
    logic out_free;   // output register can take a result
  } peml_status_t;

endpackage

// ===== rtl/peml_pix_if.sv =====
// Input pixel channel: valid/ready handshake with pixel and frame_start.
// Depends on peml_pkg.
interface peml_pix_if;
  import peml_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

// ===== rtl/peml_mag_if.sv =====
// Result channel: valid/ready handshake with edge magnitude, centre
// coordinates and end-of-frame flag. Depends on peml_pkg.
interface peml_mag_if;
  import peml_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] magnitude;
  logic [COL_W-1:0] centre_col;
  logic [ROW_W-1:0] centre_row;
  logic             frame_last;

  modport source (output valid, magnitude, centre_col, centre_row, frame_last, input ready);
  modport sink   (input valid, magnitude, centre_col, centre_row, frame_last, output ready);
endinterface

// ===== rtl/prewitt_edge_magnitude_top.sv =====
// Pixels are accepted in raster order on in_pix; each interior pixel's 3x3
// Prewitt magnitude floor(sqrt((Gx/6)^2 + (Gy/6)^2)) leaves on out_mag with
// its centre coordinates and an end-of-frame flag, emitted when the pixel
// below-right of the centre arrives; border centres give no transaction. A
// pixel with no interior window takes only the window step; one with such a
// window adds gradient, divide, square and the 8 steps of the square-root unit.
// The output register lets the next pixel in while a result waits.
// image_width (index 0) and image_height (index 1) clamp to 3..1024 and
// 3..4096; write them only while the block is idle.
// Depends on peml_pkg, peml_pix_if, peml_mag_if, peml_ctrl and peml_dp.
module prewitt_edge_magnitude_top (
  input  logic                            clk,
  input  logic                            rst_n,
  peml_pix_if.sink                        in_pix,
  peml_mag_if.source                      out_mag,
  input  logic                            cfg_we,
  input  logic [peml_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [peml_pkg::CFG_DATA_W-1:0] cfg_data
);
  import peml_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [COL_W-1:0]        width_m1;
  logic [ROW_W-1:0]        height_m1;
  peml_cmd_t               cmd;
  peml_status_t            st;
  logic                    in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp geometry to its legal range, keep last column / row index
  always_comb begin
    if (width_r < WIDTH_REG_W'(3)) begin
      width_m1 = COL_W'(2);
    end else if (width_r > WIDTH_REG_W'(MAX_WIDTH)) begin
      width_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_m1 = COL_W'(width_r - WIDTH_REG_W'(1));
    end
    if (height_r < HEIGHT_REG_W'(3)) begin
      height_m1 = ROW_W'(2);
    end else if (height_r > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      height_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_m1 = ROW_W'(height_r - HEIGHT_REG_W'(1));
    end
  end

  assign in_pix.ready = in_ready;

  peml_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pix.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  peml_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .width_m1       (width_m1),
    .height_m1      (height_m1),
    .in_pixel       (in_pix.pixel),
    .in_frame_start (in_pix.frame_start),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_mag.valid),
    .out_ready      (out_mag.ready),
    .out_magnitude  (out_mag.magnitude),
    .out_centre_col (out_mag.centre_col),
    .out_centre_row (out_mag.centre_row),
    .out_frame_last (out_mag.frame_last)
  );

endmodule

// ===== rtl/peml_ctrl.sv =====
// Sequencer for one pixel transaction: window update, gradient, divide,
// square, iterative root, output hand-off. Depends on peml_pkg.
module peml_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  peml_pkg::peml_status_t st,
  output peml_pkg::peml_cmd_t    cmd
);
  import peml_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WIN  = 7'b0000010,
    S_DIFF = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_SQR  = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        cmd.win   = 1'b1;
        state_nxt = st.emit ? S_DIFF : S_IDLE;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.root = 1'b1;
        if (st.root_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register drains
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/peml_dp.sv =====
// Datapath: line buffers, 3x3 window, position counters, Prewitt gradient,
// divide by 6, squares, bit-pair square root and output register.
// Depends on peml_pkg; driven by peml_ctrl commands.
module peml_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [peml_pkg::COL_W-1:0] width_m1,
  input  logic [peml_pkg::ROW_W-1:0] height_m1,
  input  logic [peml_pkg::PIX_W-1:0] in_pixel,
  input  logic                   in_frame_start,
  input  peml_pkg::peml_cmd_t    cmd,
  output peml_pkg::peml_status_t st,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [peml_pkg::PIX_W-1:0] out_magnitude,
  output logic [peml_pkg::COL_W-1:0] out_centre_col,
  output logic [peml_pkg::ROW_W-1:0] out_centre_row,
  output logic                   out_frame_last
);
  import peml_pkg::*;

  // line buffers, no reset: an entry read before it is written feeds no emitted window
  logic [PIX_W-1:0] row_above_mem     [MAX_WIDTH];
  logic [PIX_W-1:0] row_two_above_mem [MAX_WIDTH];

  logic [PIX_W-1:0] win_r [3][3];
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [PIX_W-1:0] pix_r, up1_r, up2_r;
  logic [COL_W-1:0] rd_addr;

  logic [COL_W-1:0] ctr_col_r;
  logic [ROW_W-1:0] ctr_row_r;
  logic             last_r;

  logic [DIFF_W-1:0] adx_r, ady_r;
  logic [Q_W-1:0]    qx_r, qy_r;
  logic [ROOT_W-1:0] rem_r, res_r, bit_r;

  logic             row_end, frame_end;
  logic [SUM_W-1:0] sum_right, sum_left, sum_bot, sum_top;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [SQ_W-1:0]  sq_sum;
  logic [ROOT_W:0]  trial;

  logic             out_valid_r;
  logic [PIX_W-1:0] mag_o_r;
  logic [COL_W-1:0] col_o_r;
  logic [ROW_W-1:0] row_o_r;
  logic             last_o_r;

  assign rd_addr   = in_frame_start ? '0 : col_r;
  assign row_end   = (col_r >= width_m1);
  assign frame_end = row_end && (row_r >= height_m1);

  assign st.emit      = (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));
  assign st.root_last = bit_r[0];
  assign st.out_free  = !out_valid_r || out_ready;

  // line buffers: read on accept, write back during the window step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      up1_r <= row_above_mem[rd_addr];
      up2_r <= row_two_above_mem[rd_addr];
      pix_r <= in_pixel;
    end
    if (cmd.win) begin
      row_above_mem[col_r]     <= pix_r;
      row_two_above_mem[col_r] <= up1_r;
    end
  end

  // position counters and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (cmd.load && in_frame_start) begin
        col_r <= '0;
        row_r <= '0;
      end
      if (cmd.win) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= up2_r;
        win_r[1][2] <= up1_r;
        win_r[2][2] <= pix_r;
        if (frame_end) begin
          col_r <= '0;
          row_r <= '0;
        end else if (row_end) begin
          col_r <= '0;
          row_r <= row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      ctr_col_r <= col_r - COL_W'(1);
      ctr_row_r <= row_r - ROW_W'(1);
      last_r    <= frame_end;
    end
  end

  // gradient magnitudes before scaling; sign drops out after squaring
  always_comb begin
    sum_right = SUM_W'(win_r[0][2]) + SUM_W'(win_r[1][2]) + SUM_W'(win_r[2][2]);
    sum_left  = SUM_W'(win_r[0][0]) + SUM_W'(win_r[1][0]) + SUM_W'(win_r[2][0]);
    sum_bot   = SUM_W'(win_r[2][0]) + SUM_W'(win_r[2][1]) + SUM_W'(win_r[2][2]);
    sum_top   = SUM_W'(win_r[0][0]) + SUM_W'(win_r[0][1]) + SUM_W'(win_r[0][2]);
  end

  assign prod_x = PROD_W'(adx_r) * PROD_W'(RECIP_6);
  assign prod_y = PROD_W'(ady_r) * PROD_W'(RECIP_6);
  assign sq_sum = SQ_W'(qx_r) * SQ_W'(qx_r) + SQ_W'(qy_r) * SQ_W'(qy_r);
  assign trial  = {1'b0, res_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      adx_r <= (sum_right >= sum_left) ? sum_right - sum_left : sum_left - sum_right;
      ady_r <= (sum_bot >= sum_top) ? sum_bot - sum_top : sum_top - sum_bot;
    end
    if (cmd.div) begin
      qx_r <= prod_x[RECIP_SHIFT +: Q_W];
      qy_r <= prod_y[RECIP_SHIFT +: Q_W];
    end
    if (cmd.sqr) begin
      rem_r <= sq_sum;
      res_r <= '0;
      bit_r <= ROOT_BIT_INIT;
    end else if (cmd.root) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r <= rem_r - trial[ROOT_W-1:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mag_o_r  <= res_r[PIX_W-1:0];
      col_o_r  <= ctr_col_r;
      row_o_r  <= ctr_row_r;
      last_o_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_magnitude  = mag_o_r;
  assign out_centre_col = col_o_r;
  assign out_centre_row = row_o_r;
  assign out_frame_last = last_o_r;

endmodule

// ===== verif/prewitt_edge_magnitude_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for prewitt_edge_magnitude_top: pixel frames go in, 3x3 edge magnitudes
// are predicted in a local model and compared per field. Depends on peml_pkg,
// peml_pix_if, peml_mag_if and the block itself.
import peml_pkg::*;

typedef struct packed {
  logic [PIX_W-1:0] magnitude;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             last;
} edge_result_t;

typedef enum int {TEX_NOISE, TEX_RAMP, TEX_STEP, TEX_EXTREME} texture_t;

// Frame dimensions act as at least 3 and at most the given ceiling
function automatic int clamp_dim(input int v, input int hi);
  if (v < 3) return 3;
  if (v > hi) return hi;
  return v;
endfunction

class magnitude_board;
  logic [PIX_W-1:0]        above1 [MAX_WIDTH];
  logic [PIX_W-1:0]        above2 [MAX_WIDTH];
  logic [PIX_W-1:0]        win [3][3];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int                      col;
  int                      row;
  int                      faults;
  edge_result_t            queued_magnitudes [$];

  function new();
    foreach (above1[i]) begin
      above1[i] = '0;
      above2[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    col    = 0;
    row    = 0;
    faults = 0;
  endfunction

  function void write_reg(input logic [CFG_IDX_W-1:0] index,
                          input logic [CFG_DATA_W-1:0] data);
    if (index == REG_IMAGE_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
    else if (index == REG_IMAGE_HEIGHT) height_reg = data[HEIGHT_REG_W-1:0];
  endfunction

  function int pending();
    return queued_magnitudes.size();
  endfunction

  function void note_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int           w, h, sum_r, sum_l, sum_b, sum_t, gx, gy, sq, root;
    logic [PIX_W-1:0] up1, up2;
    bit           row_end, frame_end;
    edge_result_t res;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (fs) begin
      col = 0;
      row = 0;
    end
    up1 = '0;
    up2 = '0;
    if (col < MAX_WIDTH) begin
      up1 = above1[col];
      up2 = above2[col];
      above2[col] = up1;
      above1[col] = px;
    end
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = px;
    row_end   = (col >= w - 1);
    frame_end = row_end && (row >= h - 1);
    if (col >= 2 && row >= 2) begin
      sum_r = win[0][2] + win[1][2] + win[2][2];
      sum_l = win[0][0] + win[1][0] + win[2][0];
      sum_b = win[2][0] + win[2][1] + win[2][2];
      sum_t = win[0][0] + win[0][1] + win[0][2];
      // signed int division truncates toward zero
      gx = (sum_r - sum_l) / 6;
      gy = (sum_b - sum_t) / 6;
      sq = gx * gx + gy * gy;
      root = 0;
      while ((root + 1) * (root + 1) <= sq) root++;
      res.magnitude = PIX_W'(root);
      res.col       = COL_W'(col - 1);
      res.row       = ROW_W'(row - 1);
      res.last      = frame_end;
      queued_magnitudes.push_back(res);
    end
    if (frame_end) begin
      col = 0;
      row = 0;
    end else if (row_end) begin
      col = 0;
      row = row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function void check_magnitude(input edge_result_t got);
    edge_result_t want;
    if (queued_magnitudes.size() == 0) begin
      $error("unexpected transaction: magnitude %0d col %0d row %0d last %0b",
             got.magnitude, got.col, got.row, got.last);
      faults++;
      return;
    end
    want = queued_magnitudes.pop_front();
    if (got.magnitude !== want.magnitude) begin
      $error("magnitude: expected %0d, actual %0d", want.magnitude, got.magnitude);
      faults++;
    end
    if (got.col !== want.col) begin
      $error("centre_col: expected %0d, actual %0d", want.col, got.col);
      faults++;
    end
    if (got.row !== want.row) begin
      $error("centre_row: expected %0d, actual %0d", want.row, got.row);
      faults++;
    end
    if (got.last !== want.last) begin
      $error("frame_last: expected %0b, actual %0b", want.last, got.last);
      faults++;
    end
  endfunction
endclass

module prewitt_edge_magnitude_top_tb;

  localparam int STUCK_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 400;

  localparam logic [PIX_W-1:0] DIRECTED_PIX [27] = '{
    8'd0,  8'd128, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd128, 8'd255,
    8'd10, 8'd10,  8'd10,  8'd0, 8'd0,   8'd0,   8'd3, 8'd2,   8'd0,
    8'd0,  8'd0,   8'd0,   8'd0, 8'd0,   8'd255, 8'd0, 8'd255, 8'd255
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  peml_pix_if pix_ch ();
  peml_mag_if mag_ch ();

  prewitt_edge_magnitude_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_ch),
    .out_mag   (mag_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  magnitude_board board;

  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  bit calm           = 1'b0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int stall_left     = 0;
  int small_items    = 0;
  int stuck          = 0;
  bit moved;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    mag_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        mag_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        mag_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = $urandom_range(0, 6);
        mag_ch.ready <= 1'b0;
      end else begin
        mag_ch.ready <= 1'b1;
      end
    end
  end

  // Track both channels and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (pix_ch.valid && pix_ch.ready) begin
        board.note_pixel(pix_ch.pixel, pix_ch.frame_start);
        moved = 1'b1;
      end
      if (mag_ch.valid && mag_ch.ready) begin
        board.check_magnitude('{mag_ch.magnitude, mag_ch.centre_col,
                                mag_ch.centre_row, mag_ch.frame_last});
        moved = 1'b1;
      end
      if (moved) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("prewitt_edge_magnitude_top_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [PIX_W-1:0] texel(input texture_t tex, input int k);
    case (tex)
      TEX_RAMP:    return PIX_W'(k * 3 + $urandom_range(0, 4));
      TEX_STEP:    return (((k >> 2) ^ (k / 7)) & 1) ? 8'd255 : 8'd0;
      TEX_EXTREME: return $urandom_range(0, 1) ? PIX_W'(255 - $urandom_range(0, 1))
                                               : PIX_W'($urandom_range(0, 1));
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_pixel(input logic [PIX_W-1:0] px, input logic fs);
    if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= px;
    pix_ch.frame_start <= fs;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    small_items++;
  endtask

  // Stream n pixels; the first carries lead_fs, the rest a rare stray frame start
  task automatic send_pixels(input int n, input texture_t tex, input bit lead_fs,
                             input int break_permille);
    for (int k = 0; k < n; k++)
      put_pixel(texel(tex, k), (k == 0) ? lead_fs
                                        : ($urandom_range(0, 999) < break_permille));
  endtask

  // Step past the last accept edge so the monitor has noted it, then wait
  task automatic drain();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
  endtask

  // Let a pixel that makes no result finish before touching the registers
  task automatic quiesce();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int h);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'(w % 2048) | (CFG_DATA_W'($urandom_range(0, 3)) << WIDTH_REG_W);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= word;
    @(posedge clk);
    board.write_reg(REG_IMAGE_WIDTH, word);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    board.write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int       phase, wreg, hreg, w_eff, h_eff, frames;
    texture_t tex;
    board = new();
    rst_n              <= 1'b0;
    pix_ch.valid       <= 1'b0;
    pix_ch.pixel       <= '0;
    pix_ch.frame_start <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_IMAGE_WIDTH;
    cfg_data           <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full-scale ramp, wrap into a frame with negative gradients, corner edge
    set_geometry(3, 3);
    foreach (DIRECTED_PIX[k])
      put_pixel(DIRECTED_PIX[k], (k == 0 || k == 18));

    // Random frames, mostly well formed, across many small geometries
    phase = 0;
    while (small_items < 420) begin
      quiesce();
      wreg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
      hreg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
      if (phase == 0) begin
        wreg = 12;
        hreg = 8;
      end
      set_geometry(wreg, hreg);
      w_eff = clamp_dim(wreg, MAX_WIDTH);
      h_eff = clamp_dim(hreg, MAX_HEIGHT);
      src_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      if (phase == 0) hold_req = 1'b1;
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        tex = texture_t'($urandom_range(0, 3));
        if (phase != 0 && $urandom_range(0, 9) == 0)
          send_pixels($urandom_range(1, w_eff * h_eff - 1), tex, 1'b1, 0);
        else
          send_pixels(w_eff * h_eff, tex, (f == 0) || $urandom_range(0, 1), 8);
        if (phase == 4 && f == 0) drain();
      end
      phase++;
    end

    // Shrink the frame while a row is in flight: the row and the frame end early
    quiesce();
    set_geometry(12, 20);
    send_pixels(12 * 5 + 8, TEX_NOISE, 1'b1, 0);
    quiesce();
    set_geometry(6, 4);
    send_pixels(1 + 2 * 6 * 4, TEX_RAMP, 1'b0, 0);

    // Width register above the limit: a short run stays inside the first line
    quiesce();
    src_gap_pct    = 5;
    sink_stall_pct = 5;
    set_geometry(2047, 3);
    send_pixels(40, TEX_NOISE, 1'b1, 0);

    // Height register above the limit; run part of a tall frame
    quiesce();
    set_geometry(5, 8191);
    send_pixels(5 * 16, TEX_STEP, 1'b1, 0);

    // Closing stretch with no idling on either side
    calm = 1'b1;
    quiesce();
    set_geometry(8, 6);
    send_pixels(8 * 6, TEX_NOISE, 1'b1, 0);
    send_pixels(8 * 6, TEX_EXTREME, 1'b0, 0);

    quiesce();
    if (board.faults == 0) begin
      $display("prewitt_edge_magnitude_top_tb: PASS");
    end else begin
      $display("prewitt_edge_magnitude_top_tb: FAIL");
    end
    $finish;
  end

endmodule
